// ===== src/trm_pkg.sv =====
// Shared types, command codes and helpers for the tiny register machine execute unit.
// Used by every module of the block but trm_checker; depends on nothing.
`default_nettype none

package trm_pkg;

   localparam int REG_COUNT      = 256;
   localparam int REG_ADDR_WIDTH = 8;
   localparam int WORD_WIDTH     = 16;

   typedef logic [REG_ADDR_WIDTH-1:0] reg_addr_type;
   typedef logic [WORD_WIDTH-1:0]     word_type;
   typedef logic [3:0]                cmd_type;

   localparam reg_addr_type FLAG_REG       = 8'hF1;
   localparam word_type     PROG_LEN_RESET = 16'hFFFF;

   localparam cmd_type CMD_NOP     = 4'd0;
   localparam cmd_type CMD_JMP     = 4'd1;
   localparam cmd_type CMD_JE      = 4'd2;
   localparam cmd_type CMD_MOV_REG = 4'd3;
   localparam cmd_type CMD_MOV_IMM = 4'd4;
   localparam cmd_type CMD_ADD_REG = 4'd5;
   localparam cmd_type CMD_ADD_IMM = 4'd6;
   localparam cmd_type CMD_CMP_REG = 4'd7;
   localparam cmd_type CMD_CMP_IMM = 4'd8;
   localparam cmd_type CMD_SYSC    = 4'd9;

   // Program counter steps per instruction length.
   localparam word_type ADV_SHORT = 16'd1;
   localparam word_type ADV_REG   = 16'd3;
   localparam word_type ADV_IMM   = 16'd4;

   typedef struct packed {
      logic         en;
      reg_addr_type addr;
      word_type     data;
   } wr_type;

   typedef struct packed {
      wr_type   wr;
      word_type next_pc;
      logic     fault;
      logic     overflow;
      logic     syscall_request;
      word_type call_number;
   } exec_type;

   function automatic logic reg_in_range(reg_addr_type addr);
      return {1'b0, addr} < (REG_ADDR_WIDTH+1)'(REG_COUNT);
   endfunction

endpackage

`default_nettype wire

// ===== src/trm_regfile.sv =====
// Register file of the tiny register machine: memory with registered reads, per-entry
// valid bits that stand for the reset value, write bypass and a copy of the flag register.
// Depends on trm_pkg.
`default_nettype none

module trm_regfile (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire trm_pkg::reg_addr_type rd_addr_a,
   input  wire trm_pkg::reg_addr_type rd_addr_b,
   input  wire trm_pkg::wr_type   wr,
   output trm_pkg::word_type      opnd_a,
   output trm_pkg::word_type      opnd_b,
   output trm_pkg::word_type      flag
);

   trm_pkg::word_type mem [trm_pkg::REG_COUNT];

   logic [trm_pkg::REG_COUNT-1:0] valid_ff, valid_in;
   trm_pkg::word_type rd_a_ff, rd_b_ff;
   trm_pkg::word_type byp_data_ff;
   logic live_a_ff, live_b_ff, live_a_in, live_b_in;
   logic byp_a_ff, byp_b_ff, byp_a_in, byp_b_in;
   trm_pkg::word_type flag_ff, flag_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   // A write landing in the same edge as the read wins over the stale memory word.
   assign byp_a_in  = wr.en && (wr.addr == rd_addr_a);
   assign byp_b_in  = wr.en && (wr.addr == rd_addr_b);
   assign live_a_in = trm_pkg::reg_in_range(rd_addr_a) && valid_ff[rd_addr_a];
   assign live_b_in = trm_pkg::reg_in_range(rd_addr_b) && valid_ff[rd_addr_b];
   assign flag_in   = (wr.en && (wr.addr == trm_pkg::FLAG_REG)) ? wr.data : flag_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         live_a_ff   <= live_a_in;
         live_b_ff   <= live_b_in;
         byp_a_ff    <= byp_a_in;
         byp_b_ff    <= byp_b_in;
         byp_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         flag_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
      end
   end

   assign opnd_a = byp_a_ff ? byp_data_ff : (live_a_ff ? rd_a_ff : '0);
   assign opnd_b = byp_b_ff ? byp_data_ff : (live_b_ff ? rd_b_ff : '0);
   assign flag   = flag_ff;

endmodule

`default_nettype wire

// ===== src/trm_exec.sv =====
// Execute logic of the tiny register machine: decodes one command and forms the register
// write, the next program counter and the result flags. Depends on trm_pkg.
`default_nettype none

module trm_exec (
   input  wire trm_pkg::cmd_type      command,
   input  wire trm_pkg::reg_addr_type dst_reg,
   input  wire trm_pkg::word_type     imm,
   input  wire trm_pkg::word_type     opnd_a,
   input  wire trm_pkg::word_type     opnd_b,
   input  wire trm_pkg::word_type     flag,
   input  wire trm_pkg::word_type     pc,
   input  wire trm_pkg::word_type     program_length,
   output trm_pkg::exec_type          result
);

   logic [trm_pkg::WORD_WIDTH:0] sum;
   trm_pkg::word_type addend;
   trm_pkg::word_type advance;
   logic jumped;
   logic dst_ok;

   assign addend = (command == trm_pkg::CMD_ADD_REG) ? opnd_b : imm;
   assign sum    = {1'b0, opnd_a} + {1'b0, addend};
   assign dst_ok = trm_pkg::reg_in_range(dst_reg);

   always_comb begin
      result         = '0;
      result.wr.addr = dst_reg;
      advance        = trm_pkg::ADV_SHORT;
      jumped         = 1'b0;
      unique case (command)
         trm_pkg::CMD_JMP: begin
            jumped = 1'b1;
            if (imm >= program_length) begin
               result.fault   = 1'b1;
               result.next_pc = pc;
            end else begin
               result.next_pc = imm;
            end
         end
         trm_pkg::CMD_JE: begin
            if (flag != '0) begin
               jumped         = 1'b1;
               result.next_pc = imm;
            end else begin
               advance = trm_pkg::ADV_REG;
            end
         end
         trm_pkg::CMD_MOV_REG: begin
            result.wr.en   = dst_ok;
            result.wr.data = opnd_b;
            advance        = trm_pkg::ADV_REG;
         end
         trm_pkg::CMD_MOV_IMM: begin
            result.wr.en   = dst_ok;
            result.wr.data = imm;
            advance        = trm_pkg::ADV_IMM;
         end
         trm_pkg::CMD_ADD_REG, trm_pkg::CMD_ADD_IMM: begin
            // A carry out of the word keeps the destination as it was.
            result.overflow = sum[trm_pkg::WORD_WIDTH];
            result.wr.en    = dst_ok && !sum[trm_pkg::WORD_WIDTH];
            result.wr.data  = sum[trm_pkg::WORD_WIDTH-1:0];
            advance = (command == trm_pkg::CMD_ADD_REG) ? trm_pkg::ADV_REG : trm_pkg::ADV_IMM;
         end
         trm_pkg::CMD_CMP_REG: begin
            result.wr.en   = trm_pkg::reg_in_range(trm_pkg::FLAG_REG);
            result.wr.addr = trm_pkg::FLAG_REG;
            result.wr.data = trm_pkg::word_type'(opnd_a == opnd_b);
            advance        = trm_pkg::ADV_REG;
         end
         trm_pkg::CMD_CMP_IMM: begin
            result.wr.en   = trm_pkg::reg_in_range(trm_pkg::FLAG_REG);
            result.wr.addr = trm_pkg::FLAG_REG;
            result.wr.data = trm_pkg::word_type'(opnd_a == imm);
            advance        = trm_pkg::ADV_IMM;
         end
         trm_pkg::CMD_SYSC: begin
            result.syscall_request = 1'b1;
            result.call_number     = imm;
            advance                = trm_pkg::ADV_REG;
         end
         default: begin
            advance = trm_pkg::ADV_SHORT;
         end
      endcase
      if (!jumped) begin
         result.next_pc = pc + advance;
      end
   end

endmodule

`default_nettype wire

// ===== src/tiny_register_machine_execute_unit.sv =====
// Top level of the tiny register machine execute unit: input stage, program counter,
// program length register and result register. Depends on trm_pkg, trm_regfile, trm_exec.
//
//   Port group   Direction   Flow control     Carries
//   req_*        in          valid / stall    one decoded instruction per beat
//   rsp_*        out         valid / stall    next pc, fault, overflow, system call per beat
//   csr_*        in          write enable     program length
//
// An instruction beat is registered together with its two register file reads, executes once
// the result register can take it and its result beat is presented from the result register;
// one beat per cycle is sustained while rsp_stall is low.
// Reset clears the program counter, the register file valid bits and the pipeline, and sets the
// program length to 0xFFFF. A stalled result holds; the input stage still takes a beat
// while the result register waits, and stalls only when both are occupied.
`default_nettype none

module tiny_register_machine_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_command,
   input  wire logic [7:0]  req_dst_reg,
   input  wire logic [7:0]  req_src_reg,
   input  wire logic [15:0] req_imm,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_next_pc,
   output logic             rsp_fault,
   output logic             rsp_overflow,
   output logic             rsp_syscall_request,
   output logic [15:0]      rsp_call_number
);

   logic accept, fire;
   logic s1_valid_ff, s1_valid_in;
   trm_pkg::cmd_type      s1_cmd_ff;
   trm_pkg::reg_addr_type s1_dst_ff;
   trm_pkg::word_type     s1_imm_ff;
   trm_pkg::word_type     pc_ff, pc_in;
   trm_pkg::word_type     plen_ff, plen_in;
   logic out_valid_ff, out_valid_in;
   trm_pkg::exec_type     out_ff;
   trm_pkg::exec_type     exec_res;
   trm_pkg::wr_type       wr;
   trm_pkg::word_type     opnd_a, opnd_b, flag;

   assign fire        = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !fire;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);
   assign pc_in       = fire ? exec_res.next_pc : pc_ff;
   assign plen_in     = csr_write_enable ? csr_write_data : plen_ff;

   always_comb begin
      wr    = exec_res.wr;
      wr.en = fire && exec_res.wr.en;
   end

   trm_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_dst_reg),
      .rd_addr_b (req_src_reg),
      .wr        (wr),
      .opnd_a    (opnd_a),
      .opnd_b    (opnd_b),
      .flag      (flag)
   );

   trm_exec u_exec (
      .command        (s1_cmd_ff),
      .dst_reg        (s1_dst_ff),
      .imm            (s1_imm_ff),
      .opnd_a         (opnd_a),
      .opnd_b         (opnd_b),
      .flag           (flag),
      .pc             (pc_ff),
      .program_length (plen_ff),
      .result         (exec_res)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= req_command;
         s1_dst_ff <= req_dst_reg;
         s1_imm_ff <= req_imm;
      end
      if (fire) begin
         out_ff <= exec_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
         plen_ff      <= trm_pkg::PROG_LEN_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
         plen_ff      <= plen_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_next_pc         = out_ff.next_pc;
   assign rsp_fault           = out_ff.fault;
   assign rsp_overflow        = out_ff.overflow;
   assign rsp_syscall_request = out_ff.syscall_request;
   assign rsp_call_number     = out_ff.call_number;

endmodule

`default_nettype wire

// ===== src/trm_checker.sv =====
// Port-level checks for the tiny register machine execute unit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module trm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_next_pc,
   input wire logic        rsp_fault,
   input wire logic        rsp_overflow,
   input wire logic        rsp_syscall_request,
   input wire logic [15:0] rsp_call_number
);

   // A result beat that is held back stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A result beat that is held back keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_next_pc) && $stable(rsp_fault)
         && $stable(rsp_overflow) && $stable(rsp_syscall_request)
         && $stable(rsp_call_number))
      else $error("stalled result beat changed");

   // Reset empties the result register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Fault, overflow and system call come from different commands.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_fault, rsp_overflow, rsp_syscall_request}) <= 1)
      else $error("more than one result indication set");

   // A call number is only reported with a system call.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_syscall_request |-> rsp_call_number == 16'd0)
      else $error("call number without system call");

endmodule

bind tiny_register_machine_execute_unit trm_checker u_trm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_next_pc         (rsp_next_pc),
   .rsp_fault           (rsp_fault),
   .rsp_overflow        (rsp_overflow),
   .rsp_syscall_request (rsp_syscall_request),
   .rsp_call_number     (rsp_call_number)
);

`default_nettype wire
